@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the descriptor sizer blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of clk, held off during reset.
`define HRDIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but evaluated through reset as well.
`define HRDIS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hrdis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdis_pkg
// Types and codes shared by the HID report descriptor input sizer.
// ----------------------------------------------------------------------------
package hrdis_pkg;

  // Short item type field (prefix bits 3:2)
  localparam logic [1:0] KIND_MAIN     = 2'd0;
  localparam logic [1:0] KIND_GLOBAL   = 2'd1;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  // Size code that stands for four data bytes
  localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
  localparam logic [2:0] LEN_FOUR       = 3'd4;

  // Main item tags
  localparam logic [3:0] TAG_INPUT      = 4'h8;
  localparam logic [3:0] TAG_OUTPUT     = 4'h9;
  localparam logic [3:0] TAG_COLLECTION = 4'hA;
  localparam logic [3:0] TAG_FEATURE    = 4'hB;
  localparam logic [3:0] TAG_END_COLL   = 4'hC;

  // Global item tags
  localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
  localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;

  // Stop cause codes; STOP_NONE never leaves the block
  typedef enum logic [1:0] {
    STOP_DEPTH    = 2'd0,
    STOP_RESERVED = 2'd1,
    STOP_END      = 2'd2,
    STOP_NONE     = 2'd3
  } stop_cause_t;

  // Registered input beat
  typedef struct packed {
    logic       valid;
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_beat_t;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic        valid;
    logic [15:0] total_bits;
    logic        multi_report;
    stop_cause_t stop_cause;
  } result_t;

endpackage

@@ rtl/hrdis_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdis_in_if
// Descriptor byte channel: valid/ready plus one byte and an end marker.
// ----------------------------------------------------------------------------
interface hrdis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last_byte;

  modport source (output valid, output desc_byte, output last_byte, input ready);
  modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

@@ rtl/hrdis_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdis_out_if
// Result channel: valid/ready plus bit total, multi-report flag and cause.
// ----------------------------------------------------------------------------
interface hrdis_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] total_bits;
  logic        multi_report;
  logic [1:0]  stop_cause;

  modport source (output valid, output total_bits, output multi_report,
                  output stop_cause, input ready);
  modport sink   (input valid, input total_bits, input multi_report,
                  input stop_cause, output ready);
endinterface

@@ rtl/hid_report_descriptor_input_sizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_report_descriptor_input_sizer
// Parses HID short items and reports Input bits (report ID 0/1) per descriptor.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_ch    in   desc_byte[7:0], last_byte
//  out_ch   out  total_bits[15:0], multi_report, stop_cause[1:0]
//
//  One byte per cycle sustained while out_ch keeps up; a byte is held in the input
//  register and its result is loaded into the result register as it advances.
//  Each byte is decoded combinationally with one 16x16 multiply-add.
//  Reset is synchronous, active low, and clears all parser state.
//  A result left waiting on out_ch holds the next byte in the input register and stalls in_ch.
// ----------------------------------------------------------------------------
module hid_report_descriptor_input_sizer (
  input  logic        clk,
  input  logic        rst_n,
  hrdis_in_if.sink    in_ch,
  hrdis_out_if.source out_ch
);

  hrdis_pkg::in_beat_t beat;
  hrdis_pkg::result_t  res;
  logic                out_free;
  logic                adv;

  // Move the held byte through the parser when the result side has room
  assign adv = beat.valid && out_free;

  hrdis_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .beat  (beat)
  );

  hrdis_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (beat),
    .adv   (adv),
    .res   (res)
  );

  hrdis_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .adv      (adv),
    .out_ch   (out_ch),
    .out_free (out_free)
  );

endmodule

@@ rtl/hrdis_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdis_in_reg
// Input register: captures one descriptor beat and holds it until advanced.
// ----------------------------------------------------------------------------
module hrdis_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  hrdis_in_if.sink           in_ch,
  input  logic               adv,
  output hrdis_pkg::in_beat_t beat
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take;

  // Accept a new beat when empty or when the held one moves on this cycle
  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.desc_byte;
      last_r <= in_ch.last_byte;
    end
  end

  assign beat.valid     = valid_r;
  assign beat.desc_byte = byte_r;
  assign beat.last_byte = last_r;

endmodule

@@ rtl/hrdis_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdis_parser
// Short-item decoder and report state; updates once per advanced beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrdis_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  hrdis_pkg::in_beat_t beat,
  input  logic                adv,
  output hrdis_pkg::result_t  res
);

  logic [2:0]  left_r,   left_nxt;
  logic [1:0]  pos_r,    pos_nxt;
  logic [15:0] value_r,  value_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [15:0] size_r,   size_nxt;
  logic [15:0] count_r,  count_nxt;
  logic [7:0]  id_r,     id_nxt;
  logic [7:0]  depth_r,  depth_nxt;
  logic [15:0] total_r,  total_nxt;
  logic        multi_r,  multi_nxt;
  logic        done_r,   done_nxt;

  logic [15:0] product;
  logic [2:0]  len;
  logic        run;
  logic [7:0]  run_prefix;
  logic [15:0] run_value;
  logic [1:0]  run_type;
  logic [3:0]  run_tag;
  logic [7:0]  depth_dec;
  hrdis_pkg::stop_cause_t cause;

  // Low 16 bits of size times count
  assign product   = 16'(size_r * count_r);
  assign depth_dec = depth_r - 8'd1;
  assign len       = (beat.desc_byte[1:0] == hrdis_pkg::SIZE_CODE_FOUR) ?
                     hrdis_pkg::LEN_FOUR : {1'b0, beat.desc_byte[1:0]};

  // Collect prefix and data bytes, then run a complete item
  always_comb begin
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    value_nxt  = value_r;
    prefix_nxt = prefix_r;
    size_nxt   = size_r;
    count_nxt  = count_r;
    id_nxt     = id_r;
    depth_nxt  = depth_r;
    total_nxt  = total_r;
    multi_nxt  = multi_r;
    done_nxt   = done_r;
    run        = 1'b0;
    run_prefix = beat.desc_byte;
    run_value  = 16'd0;
    cause      = hrdis_pkg::STOP_NONE;

    if (!done_r) begin
      if (left_r == 3'd0) begin
        if (len == 3'd0) begin
          run = 1'b1;
        end else begin
          prefix_nxt = beat.desc_byte;
          value_nxt  = 16'd0;
          pos_nxt    = 2'd0;
          left_nxt   = len;
        end
      end else begin
        // Only the low two data bytes are ever used
        if (pos_r == 2'd0) begin
          value_nxt[7:0] = beat.desc_byte;
        end else if (pos_r == 2'd1) begin
          value_nxt[15:8] = beat.desc_byte;
        end
        pos_nxt    = pos_r + 2'd1;
        left_nxt   = left_r - 3'd1;
        run        = (left_r == 3'd1);
        run_prefix = prefix_r;
        run_value  = value_nxt;
      end
    end

    run_type = run_prefix[3:2];
    run_tag  = run_prefix[7:4];

    if (run) begin
      if (run_type == hrdis_pkg::KIND_RESERVED) begin
        cause = hrdis_pkg::STOP_RESERVED;
      end else if (run_type == hrdis_pkg::KIND_MAIN) begin
        case (run_tag) inside
          hrdis_pkg::TAG_INPUT: begin
            if (id_r == 8'd0 || id_r == 8'd1) begin
              total_nxt = total_r + product;
            end
          end
          hrdis_pkg::TAG_OUTPUT, hrdis_pkg::TAG_FEATURE: begin
            size_nxt  = 16'd0;
            count_nxt = 16'd0;
          end
          hrdis_pkg::TAG_COLLECTION: begin
            depth_nxt = depth_r + 8'd1;
          end
          hrdis_pkg::TAG_END_COLL: begin
            depth_nxt = depth_dec;
            if (depth_dec == 8'd0) begin
              cause = hrdis_pkg::STOP_DEPTH;
            end
          end
          default: begin
          end
        endcase
      end else if (run_type == hrdis_pkg::KIND_GLOBAL) begin
        case (run_tag)
          hrdis_pkg::TAG_REPORT_SIZE:  size_nxt  = run_value;
          hrdis_pkg::TAG_REPORT_COUNT: count_nxt = run_value;
          hrdis_pkg::TAG_REPORT_ID: begin
            id_nxt    = run_value[7:0];
            multi_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    if (!done_r && cause == hrdis_pkg::STOP_NONE && beat.last_byte) begin
      cause = hrdis_pkg::STOP_END;
    end
    if (cause != hrdis_pkg::STOP_NONE) begin
      done_nxt = 1'b1;
    end
  end

  // Result carries the totals after this beat's item
  assign res.valid        = adv && (cause != hrdis_pkg::STOP_NONE);
  assign res.total_bits   = total_nxt;
  assign res.multi_report = multi_nxt;
  assign res.stop_cause   = cause;

  // State update; the final byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (adv && beat.last_byte)) begin
      left_r   <= 3'd0;
      pos_r    <= 2'd0;
      value_r  <= 16'd0;
      prefix_r <= 8'd0;
      size_r   <= 16'd0;
      count_r  <= 16'd0;
      id_r     <= 8'd0;
      depth_r  <= 8'd0;
      total_r  <= 16'd0;
      multi_r  <= 1'b0;
      done_r   <= 1'b0;
    end else if (adv) begin
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      value_r  <= value_nxt;
      prefix_r <= prefix_nxt;
      size_r   <= size_nxt;
      count_r  <= count_nxt;
      id_r     <= id_nxt;
      depth_r  <= depth_nxt;
      total_r  <= total_nxt;
      multi_r  <= multi_nxt;
      done_r   <= done_nxt;
    end
  end

  `HRDIS_ASSERT(a_no_result_after_stop, res.valid |-> !done_r,
    "result produced after parsing had stopped")
  `HRDIS_ASSERT(a_end_clears_state, (adv && beat.last_byte) |=>
    (!done_r && left_r == 3'd0 && depth_r == 8'd0 && total_r == 16'd0),
    "state not cleared after final byte")
  `HRDIS_ASSERT(a_last_gives_result, (adv && beat.last_byte && !done_r) |-> res.valid,
    "final byte of a running descriptor gave no result")
  `HRDIS_ASSERT(a_data_count_range, left_r <= hrdis_pkg::LEN_FOUR,
    "data byte count out of range")

endmodule

@@ rtl/hrdis_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrdis_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrdis_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  hrdis_pkg::result_t res,
  input  logic               adv,
  hrdis_out_if.source        out_ch,
  output logic               out_free
);

  logic        valid_r, valid_nxt;
  logic [15:0] total_r;
  logic        multi_r;
  logic [1:0]  cause_r;

  // Room for a new result when empty or draining this cycle
  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = res.valid;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload only with a fresh result
  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      total_r <= res.total_bits;
      multi_r <= res.multi_report;
      cause_r <= res.stop_cause;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.total_bits   = total_r;
  assign out_ch.multi_report = multi_r;
  assign out_ch.stop_cause   = cause_r;

  `HRDIS_ASSERT(a_no_overwrite, adv |-> out_free,
    "parser advanced into a full result register")
  `HRDIS_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> !valid_r,
    "result valid right after reset")

endmodule
